// File: src/lats_pkg.sv
// ----------------------------------------------------------------------------
// lats_pkg
// Shared constants, types and helper functions of the toroidal Life stepper.
// ----------------------------------------------------------------------------
package lats_pkg;

   // Grid store size
   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 128;

   localparam int ROW_W = $clog2(MAX_ROWS);      // row address
   localparam int COL_W = $clog2(MAX_COLS);      // column address
   localparam int NR_W  = $clog2(MAX_ROWS + 1);  // row count in use
   localparam int NC_W  = $clog2(MAX_COLS + 1);  // column count in use

   // Row memory: two banks of MAX_ROWS rows each
   localparam int MEM_DEPTH = 2 * MAX_ROWS;
   localparam int MEM_ADDR_W = ROW_W + 1;

   // Step sweep: one read per stored row plus two wrap rows
   localparam int STEP_LAST  = MAX_ROWS + 1;
   localparam int STEP_CNT_W = $clog2(MAX_ROWS + 2);

   // Field widths
   localparam int CMD_W = 2;
   localparam int GEN_W = 16;

   // Configuration registers
   localparam int ROWS_REG_W = 6;
   localparam int COLS_REG_W = 8;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = ROWS_REG_W'(25);
   localparam logic [COLS_REG_W-1:0] COLS_RESET = COLS_REG_W'(80);

   // Stream data layout
   localparam int REQ_ROW_LSB   = CMD_W;
   localparam int REQ_COL_LSB   = CMD_W + ROW_W;
   localparam int REQ_ALIVE_BIT = CMD_W + ROW_W + COL_W;
   localparam int REQ_FIELD_W   = CMD_W + ROW_W + COL_W + 1;
   localparam int REQ_DATA_W    = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W   = GEN_W + 2;
   localparam int RSP_DATA_W    = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_STEP  = 2'd2
   } lats_op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } lats_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL,
      ST_STEP,
      ST_DRAIN,
      ST_DONE
   } lats_state_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             alive_in;
   } lats_req_type;

   typedef struct packed {
      logic             alive_out;
      logic [GEN_W-1:0] generation;
      logic             out_of_range;
   } lats_rsp_type;

   // Saturate the row register to the legal range
   function automatic logic [NR_W-1:0] clamp_rows(input logic [ROWS_REG_W-1:0] v);
      logic [NR_W-1:0] r;
      if (int'(v) < 3) r = NR_W'(3);
      else if (int'(v) > MAX_ROWS) r = NR_W'(MAX_ROWS);
      else r = NR_W'(v);
      return r;
   endfunction

   // Saturate the column register to the legal range
   function automatic logic [NC_W-1:0] clamp_cols(input logic [COLS_REG_W-1:0] v);
      logic [NC_W-1:0] r;
      if (int'(v) < 3) r = NC_W'(3);
      else if (int'(v) > MAX_COLS) r = NC_W'(MAX_COLS);
      else r = NC_W'(v);
      return r;
   endfunction

   // B3/S23: birth on three, survive on two
   function automatic logic next_cell(input logic [3:0] n, input logic cur);
      logic r;
      case (n)
         4'd3:    r = 1'b1;
         4'd2:    r = cur;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// File: src/lats_ram.sv
// ----------------------------------------------------------------------------
// lats_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lats_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/lats_row_rule.sv
// ----------------------------------------------------------------------------
// lats_row_rule
// Next generation of one grid row from a three-row window, one lane per column,
// with horizontal wrap at the column count in use.
// ----------------------------------------------------------------------------
module lats_row_rule (
   input  logic [lats_pkg::MAX_COLS-1:0] up_row,
   input  logic [lats_pkg::MAX_COLS-1:0] mid_row,
   input  logic [lats_pkg::MAX_COLS-1:0] dn_row,
   input  logic [lats_pkg::NC_W-1:0]     nc,
   output logic [lats_pkg::MAX_COLS-1:0] next_row
);

   logic [lats_pkg::COL_W-1:0] last_col;
   logic                       up_last;
   logic                       mid_last;
   logic                       dn_last;

   // Pick the wrap-around column once per row
   assign last_col = lats_pkg::COL_W'(nc - lats_pkg::NC_W'(1));
   assign up_last  = up_row[last_col];
   assign mid_last = mid_row[last_col];
   assign dn_last  = dn_row[last_col];

   for (genvar c = 0; c < lats_pkg::MAX_COLS; c++) begin : g_lane
      logic       up_l, mid_l, dn_l;
      logic       up_r, mid_r, dn_r;
      logic [3:0] n;
      logic       in_use;

      // Left neighbors: column zero wraps to the last column in use
      if (c == 0) begin : g_left_wrap
         assign up_l  = up_last;
         assign mid_l = mid_last;
         assign dn_l  = dn_last;
      end else begin : g_left
         assign up_l  = up_row[c-1];
         assign mid_l = mid_row[c-1];
         assign dn_l  = dn_row[c-1];
      end

      // Right neighbors: the last column in use wraps to column zero
      if (c == lats_pkg::MAX_COLS - 1) begin : g_right_wrap
         assign up_r  = up_row[0];
         assign mid_r = mid_row[0];
         assign dn_r  = dn_row[0];
      end else begin : g_right
         logic wrap;
         assign wrap  = (nc == lats_pkg::NC_W'(c + 1));
         assign up_r  = wrap ? up_row[0]  : up_row[c+1];
         assign mid_r = wrap ? mid_row[0] : mid_row[c+1];
         assign dn_r  = wrap ? dn_row[0]  : dn_row[c+1];
      end

      // Count live neighbors
      assign n = 4'(up_l) + 4'(up_row[c]) + 4'(up_r)
               + 4'(mid_l) + 4'(mid_r)
               + 4'(dn_l) + 4'(dn_row[c]) + 4'(dn_r);

      // Columns beyond the grid in use keep their value
      assign in_use      = (lats_pkg::NC_W'(c) < nc);
      assign next_row[c] = in_use ? lats_pkg::next_cell(n, mid_row[c]) : mid_row[c];
   end

endmodule

// File: src/lats_engine.sv
// ----------------------------------------------------------------------------
// lats_engine
// Command sequencer around the two-bank row memory: cell read-modify-write,
// cell read, and the generation sweep with its three-row window.
// ----------------------------------------------------------------------------
module lats_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lats_pkg::lats_req_type     req,
   input  logic [lats_pkg::NR_W-1:0]  nr,
   input  logic [lats_pkg::NC_W-1:0]  nc,
   output logic                       res_valid,
   input  logic                       res_ready,
   output lats_pkg::lats_rsp_type     res
);

   // Sweep pipeline tag: read data return, then write of the finished row
   typedef struct packed {
      logic                      vld;
      logic                      wr;
      logic                      compute;
      logic [lats_pkg::ROW_W-1:0] dst;
   } lats_tag_type;

   lats_pkg::lats_state_type state_ff, state_in;
   lats_pkg::lats_req_type   cmd_ff, cmd_in;
   lats_pkg::lats_rsp_type   res_ff, res_in;
   logic                     bank_ff, bank_in;
   logic [lats_pkg::MAX_ROWS-1:0] valid_ff, valid_in;
   logic [lats_pkg::GEN_W-1:0]    gen_ff, gen_in;
   logic [lats_pkg::STEP_CNT_W-1:0] step_ff, step_in;
   lats_tag_type             s1_ff, s1_in, s2_ff, s2_in;
   logic [lats_pkg::ROW_W-1:0] rd_row_ff, rd_row;
   logic [lats_pkg::MAX_COLS-1:0] win_up_ff, win_up_in;
   logic [lats_pkg::MAX_COLS-1:0] win_mid_ff, win_mid_in;
   logic [lats_pkg::MAX_COLS-1:0] win_dn_ff, win_dn_in;

   logic                          mem_we;
   logic [lats_pkg::MEM_ADDR_W-1:0] mem_waddr;
   logic [lats_pkg::MAX_COLS-1:0] mem_wdata;
   logic [lats_pkg::MAX_COLS-1:0] mem_rdata;
   logic [lats_pkg::MAX_COLS-1:0] row_data;
   logic [lats_pkg::MAX_COLS-1:0] rule_row;
   logic [lats_pkg::ROW_W-1:0]    step_row;
   logic                          outside;

   // Row memory: bank bit on top of the row address
   lats_ram #(
      .WIDTH (lats_pkg::MAX_COLS),
      .DEPTH (lats_pkg::MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr ({bank_ff, rd_row}),
      .rdata (mem_rdata)
   );

   // Next generation of the middle window row
   lats_row_rule u_rule (
      .up_row   (win_up_ff),
      .mid_row  (win_mid_ff),
      .dn_row   (win_dn_ff),
      .nc       (nc),
      .next_row (rule_row)
   );

   // Rows never written since reset read as dead
   assign row_data = valid_ff[rd_row_ff] ? mem_rdata : '0;

   assign outside = (lats_pkg::NR_W'(req.row) >= nr) || (lats_pkg::NC_W'(req.col) >= nc);

   // Sweep read order: last row, rows 0 to nr-1, row 0 again, then the rows
   // beyond the grid in use
   always_comb begin
      if (step_ff == '0) begin
         step_row = lats_pkg::ROW_W'(nr - lats_pkg::NR_W'(1));
      end else if (int'(step_ff) <= int'(nr)) begin
         step_row = lats_pkg::ROW_W'(step_ff - lats_pkg::STEP_CNT_W'(1));
      end else if (int'(step_ff) == int'(nr) + 1) begin
         step_row = '0;
      end else begin
         step_row = lats_pkg::ROW_W'(step_ff - lats_pkg::STEP_CNT_W'(2));
      end
   end

   // State register and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lats_pkg::ST_IDLE;
         bank_ff  <= 1'b0;
         valid_ff <= '0;
         gen_ff   <= '0;
         s1_ff    <= '0;
         s2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         valid_ff <= valid_in;
         gen_ff   <= gen_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
      step_ff    <= step_in;
      rd_row_ff  <= rd_row;
      win_up_ff  <= win_up_in;
      win_mid_ff <= win_mid_in;
      win_dn_ff  <= win_dn_in;
   end

   // Next state and outputs
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      res_in     = res_ff;
      bank_in    = bank_ff;
      valid_in   = valid_ff;
      gen_in     = gen_ff;
      step_in    = step_ff;
      s1_in      = '0;
      s2_in      = s1_ff;
      rd_row     = req.row;
      win_up_in  = win_up_ff;
      win_mid_in = win_mid_ff;
      win_dn_in  = win_dn_ff;
      mem_we     = 1'b0;
      mem_waddr  = {bank_ff, cmd_ff.row};
      mem_wdata  = row_data;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      // Advance the window as sweep data returns
      if (s1_ff.vld) begin
         win_up_in  = win_mid_ff;
         win_mid_in = win_dn_ff;
         win_dn_in  = row_data;
      end

      // Write a finished or copied row into the other bank
      if (s2_ff.vld && s2_ff.wr) begin
         mem_we    = 1'b1;
         mem_waddr = {~bank_ff, s2_ff.dst};
         mem_wdata = s2_ff.compute ? rule_row : win_dn_ff;
      end

      unique case (state_ff)
         lats_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = req;
               res_in = '{alive_out: 1'b0, generation: gen_ff, out_of_range: 1'b0};
               unique case (lats_pkg::lats_op_type'(req.command)) inside
                  lats_pkg::CMD_WRITE, lats_pkg::CMD_READ: begin
                     if (outside) begin
                        res_in.out_of_range = 1'b1;
                        state_in = lats_pkg::ST_DONE;
                     end else begin
                        state_in = lats_pkg::ST_CELL;
                     end
                  end
                  lats_pkg::CMD_STEP: begin
                     step_in  = '0;
                     state_in = lats_pkg::ST_STEP;
                  end
                  default: begin
                     state_in = lats_pkg::ST_DONE;
                  end
               endcase
            end
         end

         lats_pkg::ST_CELL: begin
            // Row data arrives; read a bit or merge a bit and write back
            if (lats_pkg::lats_op_type'(cmd_ff.command) == lats_pkg::CMD_WRITE) begin
               mem_we                 = 1'b1;
               mem_waddr              = {bank_ff, cmd_ff.row};
               mem_wdata              = row_data;
               mem_wdata[cmd_ff.col]  = cmd_ff.alive_in;
               valid_in[cmd_ff.row]   = 1'b1;
            end else begin
               res_in.alive_out = row_data[cmd_ff.col];
            end
            state_in = lats_pkg::ST_DONE;
         end

         lats_pkg::ST_STEP: begin
            // Issue one sweep read per cycle
            rd_row        = step_row;
            s1_in.vld     = 1'b1;
            s1_in.wr      = (int'(step_ff) >= 2);
            s1_in.compute = (int'(step_ff) <= int'(nr) + 1);
            s1_in.dst     = lats_pkg::ROW_W'(step_ff - lats_pkg::STEP_CNT_W'(2));
            step_in       = step_ff + lats_pkg::STEP_CNT_W'(1);
            if (step_ff == lats_pkg::STEP_CNT_W'(lats_pkg::STEP_LAST)) begin
               state_in = lats_pkg::ST_DRAIN;
            end
         end

         lats_pkg::ST_DRAIN: begin
            // Swap banks once the last row is written
            if (!s1_ff.vld && !s2_ff.vld) begin
               bank_in           = ~bank_ff;
               valid_in          = '1;
               gen_in            = gen_ff + lats_pkg::GEN_W'(1);
               res_in.generation = gen_ff + lats_pkg::GEN_W'(1);
               state_in          = lats_pkg::ST_DONE;
            end
         end

         lats_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = lats_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lats_pkg::ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

// File: src/life_automaton_toroidal_step.sv
// ----------------------------------------------------------------------------
// life_automaton_toroidal_step
// Toroidal Life (B3/S23) grid engine with cell write, cell read and step.
// ----------------------------------------------------------------------------
// The grid is kept as rows of MAX_COLS cells in one row memory with two banks;
// each request transaction gives exactly one response transaction. A cell
// write or read reads its row through the registered read port, then merges
// the bit into the row and writes it back, or picks out the bit. In a step,
// the single read port of the row memory sweeps the whole bank, the last row,
// every row of the grid in use, row 0 again for the wrap, and the rows beyond
// the grid, which are copied unchanged; each finished row is written into the
// other bank, and the banks swap at the end. Per-row valid bits make the grid
// read as all dead after reset, so no clearing pass is needed. Grid size
// registers saturate to 3..MAX_ROWS and 3..MAX_COLS; write them only while idle.
// A new request is taken while the previous response still waits.
module life_automaton_toroidal_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // command[1:0], row[6:2], col[13:7], alive_in[14], zero[15]
   input  logic [lats_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // alive_out[0], generation[16:1], out_of_range[17], zero[23:18]
   output logic [lats_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [lats_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lats_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RSP_PAD_W = lats_pkg::RSP_DATA_W - lats_pkg::RSP_FIELD_W;

   logic [lats_pkg::ROWS_REG_W-1:0] rows_ff, rows_in;
   logic [lats_pkg::COLS_REG_W-1:0] cols_ff, cols_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   lats_pkg::lats_rsp_type          rsp_data_ff, rsp_data_in;
   lats_pkg::lats_req_type          req;
   lats_pkg::lats_rsp_type          res;
   logic                            res_valid;
   logic                            slot_free;
   logic [lats_pkg::NR_W-1:0]       nr;
   logic [lats_pkg::NC_W-1:0]       nc;

   // Unpack request fields
   assign req.command  = req_tdata[0 +: lats_pkg::CMD_W];
   assign req.row      = req_tdata[lats_pkg::REQ_ROW_LSB +: lats_pkg::ROW_W];
   assign req.col      = req_tdata[lats_pkg::REQ_COL_LSB +: lats_pkg::COL_W];
   assign req.alive_in = req_tdata[lats_pkg::REQ_ALIVE_BIT];

   // Configuration registers
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (lats_pkg::lats_csr_type'(csr_addr))
            lats_pkg::CSR_ROWS: rows_in = csr_wdata[lats_pkg::ROWS_REG_W-1:0];
            lats_pkg::CSR_COLS: cols_in = lats_pkg::COLS_REG_W'(csr_wdata);
            default:            rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= lats_pkg::ROWS_RESET;
         cols_ff <= lats_pkg::COLS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Effective grid size
   assign nr = lats_pkg::clamp_rows(rows_ff);
   assign nc = lats_pkg::clamp_cols(cols_ff);

   lats_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .nr        (nr),
      .nc        (nc),
      .res_valid (res_valid),
      .res_ready (slot_free),
      .res       (res)
   );

   // Output register: load when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Pack response fields
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff.out_of_range,
                        rsp_data_ff.generation, rsp_data_ff.alive_out};

endmodule

// File: src/lats_checker.sv
// ----------------------------------------------------------------------------
// lats_checker
// Port-level checks of the Life stepper, bound to the top level.
// ----------------------------------------------------------------------------
module lats_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lats_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            csr_we
);

   logic                         req_acc;
   logic                         rsp_acc;
   logic [2:0]                   pend_ff, pend_in;
   logic [lats_pkg::GEN_W-1:0]   last_gen_ff, last_gen_in;
   logic [lats_pkg::GEN_W-1:0]   rsp_gen;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_acc  = rsp_tvalid && rsp_tready;
   assign rsp_gen  = rsp_tdata[1 +: lats_pkg::GEN_W];

   // Track transactions in flight and the last delivered generation
   always_comb begin
      pend_in     = pend_ff + 3'(req_acc) - 3'(rsp_acc);
      last_gen_in = rsp_acc ? rsp_gen : last_gen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         last_gen_ff <= '0;
      end else begin
         pend_ff     <= pend_in;
         last_gen_ff <= last_gen_in;
      end
   end

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // At most two transactions in flight; no response without a request
   a_pending: assert property (@(posedge clock) disable iff (reset)
      (pend_ff <= 3'd2) && (!rsp_tvalid || pend_ff != 3'd0))
      else $error("response count out of step with requests");

   // Generation moves by at most one between responses
   a_gen_step: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (rsp_gen == last_gen_ff) ||
                  (rsp_gen == lats_pkg::GEN_W'(last_gen_ff + 1'b1)))
      else $error("generation jumped");

   // A flagged access never returns a live cell
   a_oor_dead: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[lats_pkg::GEN_W + 1]))
      else $error("live cell on an out-of-range access");

   // Size registers change only with nothing in flight
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_we |-> (pend_ff == 3'd0))
      else $error("size register written with transactions in flight");

endmodule

bind life_automaton_toroidal_step lats_checker u_lats_checker (.*);
